// ----- rtl/core/bpsm_pkg.sv -----
// bpsm_pkg: shared types, constants and helpers of the battery power-state monitor.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package bpsm_pkg;

  localparam int unsigned MvW    = 14;
  localparam int unsigned MsW    = 32;
  localparam int unsigned LevelW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned LevelSteps = 9;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_VOLTAGE      = 3'd0,
    CFG_CRITICAL_VOLTAGE = 3'd1,
    CFG_LOW_TIMEOUT      = 3'd2,
    CFG_CRITICAL_TIMEOUT = 3'd3,
    CFG_IDLE_SHUTDOWN    = 3'd4,
    CFG_REPORT_INTERVAL  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PS_BATTERY  = 2'd0,
    PS_CHARGING = 2'd1,
    PS_CHARGED  = 2'd2,
    PS_LOWPOWER = 2'd3
  } power_state_e;

  // reset values
  localparam logic [MvW-1:0] LowVoltageRst      = 14'd3200;
  localparam logic [MvW-1:0] CriticalVoltageRst = 14'd3000;
  localparam logic [MsW-1:0] LowTimeoutRst      = 32'd5000;
  localparam logic [MsW-1:0] CriticalTimeoutRst = 32'd5000;
  localparam logic [MsW-1:0] IdleShutdownRst    = 32'd300000;
  localparam logic [MsW-1:0] ReportIntervalRst  = 32'd1000;
  localparam logic [MvW-1:0] SeenRst            = 14'd3700;

  // level thresholds in mV; level_pct compares only the first nine, the last entry is unused
  localparam logic [MvW-1:0] LevelTable [LevelSteps+1] = '{
    14'd3000, 14'd3780, 14'd3830, 14'd3870, 14'd3890,
    14'd3920, 14'd3960, 14'd4000, 14'd4040, 14'd4100
  };

  typedef struct packed {
    logic [MvW-1:0] low_voltage_mv;
    logic [MvW-1:0] critical_voltage_mv;
    logic [MsW-1:0] low_timeout_ms;
    logic [MsW-1:0] critical_timeout_ms;
    logic [MsW-1:0] idle_shutdown_ms;
    logic [MsW-1:0] report_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [MvW-1:0] voltage_mv;
    logic           is_charging;
    logic           power_good;
    logic [MsW-1:0] now_ms;
    logic [MsW-1:0] inactive_ms;
  } sample_t;

  typedef struct packed {
    logic [LevelW-1:0] level_pct;
    power_state_e      power_state;
    logic              state_changed;
    logic              may_fly;
    logic              shutdown_req;
    logic              report_pulse;
    logic [MvW-1:0]    min_mv;
    logic [MvW-1:0]    max_mv;
  } result_t;

  // Charge level in percent: ten per threshold the voltage lies above.
  // Below the first entry nothing is passed; above the ninth all nine count.
  function automatic logic [LevelW-1:0] level_pct(input logic [MvW-1:0] mv);
    logic [3:0] steps;
    steps = '0;
    for (int i = 0; i < LevelSteps; i++) begin
      if (mv > LevelTable[i]) begin
        steps = steps + 4'd1;
      end
    end
    return LevelW'({steps, 3'b000} + {2'b00, steps, 1'b0});
  endfunction

endpackage

// ----- rtl/core/bpsm_cfg.sv -----
// bpsm_cfg: configuration register file of the battery power-state monitor.
// Depends on bpsm_pkg.
`timescale 1ns / 1ps

module bpsm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [bpsm_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [bpsm_pkg::CfgDataW-1:0] wr_data_i,
  output bpsm_pkg::cfg_t                cfg_o
);
  import bpsm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CFG_LOW_VOLTAGE:      cfg_d.low_voltage_mv      = wr_data_i[MvW-1:0];
        CFG_CRITICAL_VOLTAGE: cfg_d.critical_voltage_mv = wr_data_i[MvW-1:0];
        CFG_LOW_TIMEOUT:      cfg_d.low_timeout_ms      = wr_data_i[MsW-1:0];
        CFG_CRITICAL_TIMEOUT: cfg_d.critical_timeout_ms = wr_data_i[MsW-1:0];
        CFG_IDLE_SHUTDOWN:    cfg_d.idle_shutdown_ms    = wr_data_i[MsW-1:0];
        CFG_REPORT_INTERVAL:  cfg_d.report_interval_ms  = wr_data_i[MsW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_voltage_mv      <= LowVoltageRst;
      cfg_q.critical_voltage_mv <= CriticalVoltageRst;
      cfg_q.low_timeout_ms      <= LowTimeoutRst;
      cfg_q.critical_timeout_ms <= CriticalTimeoutRst;
      cfg_q.idle_shutdown_ms    <= IdleShutdownRst;
      cfg_q.report_interval_ms  <= ReportIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/bpsm_eval.sv -----
// bpsm_eval: per-sample evaluation, tracking state and result register.
// Depends on bpsm_pkg.
`timescale 1ns / 1ps

module bpsm_eval (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,     // sample register moves into result register
  input  bpsm_pkg::sample_t sample_i,
  input  bpsm_pkg::cfg_t    cfg_i,
  output bpsm_pkg::result_t result_o
);
  import bpsm_pkg::*;

  logic [MvW-1:0] lowest_q, lowest_d;
  logic [MvW-1:0] highest_q, highest_d;
  logic [MsW-1:0] low_since_q, low_since_d;
  logic [MsW-1:0] crit_since_q, crit_since_d;
  logic [MsW-1:0] last_report_q, last_report_d;
  power_state_e   prior_q, state_d;
  result_t        result_q, result_d;

  logic           pulse;
  logic           shutdown;
  logic [MsW-1:0] since_report, low_elapsed, crit_elapsed;

  always_comb begin
    highest_d = (sample_i.voltage_mv > highest_q) ? sample_i.voltage_mv : highest_q;
    lowest_d  = (sample_i.voltage_mv < lowest_q)  ? sample_i.voltage_mv : lowest_q;

    since_report  = sample_i.now_ms - last_report_q;
    pulse         = (since_report >= cfg_i.report_interval_ms);
    last_report_d = pulse ? sample_i.now_ms : last_report_q;

    // timers restart while the voltage sits above their thresholds
    low_since_d  = (sample_i.voltage_mv > cfg_i.low_voltage_mv) ?
                   sample_i.now_ms : low_since_q;
    crit_since_d = (sample_i.voltage_mv > cfg_i.critical_voltage_mv) ?
                   sample_i.now_ms : crit_since_q;
    low_elapsed  = sample_i.now_ms - low_since_d;
    crit_elapsed = sample_i.now_ms - crit_since_d;

    if (sample_i.power_good && !sample_i.is_charging) begin
      state_d = PS_CHARGED;
    end else if (sample_i.power_good) begin
      state_d = PS_CHARGING;
    end else if (!sample_i.is_charging && (low_elapsed > cfg_i.low_timeout_ms)) begin
      state_d = PS_LOWPOWER;
    end else begin
      state_d = PS_BATTERY;
    end

    case (state_d)
      PS_LOWPOWER: shutdown = (crit_elapsed > cfg_i.critical_timeout_ms);
      PS_BATTERY:  shutdown = (sample_i.inactive_ms > cfg_i.idle_shutdown_ms);
      default:     shutdown = 1'b0;
    endcase

    result_d.level_pct     = level_pct(sample_i.voltage_mv);
    result_d.power_state   = state_d;
    result_d.state_changed = (state_d != prior_q);
    result_d.may_fly       = (state_d == PS_BATTERY) || (state_d == PS_LOWPOWER);
    result_d.shutdown_req  = shutdown;
    result_d.report_pulse  = pulse;
    result_d.min_mv        = lowest_d;
    result_d.max_mv        = highest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_q      <= SeenRst;
      highest_q     <= SeenRst;
      low_since_q   <= '0;
      crit_since_q  <= '0;
      last_report_q <= '0;
      prior_q       <= PS_BATTERY;
    end else if (step_i) begin
      lowest_q      <= lowest_d;
      highest_q     <= highest_d;
      low_since_q   <= low_since_d;
      crit_since_q  <= crit_since_d;
      last_report_q <= last_report_d;
      prior_q       <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- rtl/core/battery_power_state_monitor.sv -----
// battery_power_state_monitor: top level, handshake and two-register pipeline.
// Depends on bpsm_pkg, bpsm_cfg and bpsm_eval.
//
// Usage:
//   Sample channel: in_valid_i / in_stall_o. A request is taken at a rising
//   edge with in_valid_i high and in_stall_o low; it lands in a sample register.
//   Result channel: out_valid_o / out_stall_i. Exactly one result per sample.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i;
//   cfg_ready_o is always high, unmapped indexes are dropped. Write only while
//   no sample is in flight.
//   Path: sample request into the sample register, then evaluation logic into
//   the result register, which drives out_valid_o.
//   Throughput: one sample per cycle unless stalled, both registers advancing
//   together; tracking state updates as a sample moves into the result register.
//   Stall: while out_stall_i holds a pending result, the result register holds;
//   one more sample can still be taken into the sample register, after which
//   in_stall_o rises until the result is taken.
//   Reset (rst_ni low, async): pipeline empties, config returns to defaults,
//   min/max restart at 3700 mV, timers and report stamp at 0, state battery.
`timescale 1ns / 1ps

module battery_power_state_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bpsm_pkg::MvW-1:0]      voltage_mv_i,
  input  logic                          is_charging_i,
  input  logic                          power_good_i,
  input  logic [bpsm_pkg::MsW-1:0]      now_ms_i,
  input  logic [bpsm_pkg::MsW-1:0]      inactive_ms_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bpsm_pkg::LevelW-1:0]   level_pct_o,
  output logic [1:0]                    power_state_o,
  output logic                          state_changed_o,
  output logic                          may_fly_o,
  output logic                          shutdown_req_o,
  output logic                          report_pulse_o,
  output logic [bpsm_pkg::MvW-1:0]      min_mv_o,
  output logic [bpsm_pkg::MvW-1:0]      max_mv_o,
  // config channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bpsm_pkg::CfgDataW-1:0] cfg_data_i
);
  import bpsm_pkg::*;

  cfg_t    cfg;
  sample_t sample_q;
  result_t result;
  logic    smp_valid_q, smp_valid_d;
  logic    res_valid_q, res_valid_d;
  logic    res_free;   // result register can load this cycle
  logic    step;       // sample moves into result register
  logic    take;       // new sample request accepted

  assign cfg_ready_o = 1'b1;

  bpsm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign res_free   = !res_valid_q || !out_stall_i;
  assign step       = smp_valid_q && res_free;
  assign in_stall_o = smp_valid_q && !res_free;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    smp_valid_d = take || (smp_valid_q && !res_free);
    res_valid_d = step || (res_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      smp_valid_q <= smp_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sample_q.voltage_mv  <= voltage_mv_i;
      sample_q.is_charging <= is_charging_i;
      sample_q.power_good  <= power_good_i;
      sample_q.now_ms      <= now_ms_i;
      sample_q.inactive_ms <= inactive_ms_i;
    end
  end

  bpsm_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign out_valid_o     = res_valid_q;
  assign level_pct_o     = result.level_pct;
  assign power_state_o   = result.power_state;
  assign state_changed_o = result.state_changed;
  assign may_fly_o       = result.may_fly;
  assign shutdown_req_o  = result.shutdown_req;
  assign report_pulse_o  = result.report_pulse;
  assign min_mv_o        = result.min_mv;
  assign max_mv_o        = result.max_mv;

endmodule

// ----- tb/sv/tb_battery_power_state_monitor.sv -----
// tb_battery_power_state_monitor: self-checking bench for the battery power-state monitor.
// Drives sample and register writes, predicts or tables each status result, checks it per field.
// Depends on bpsm_pkg and battery_power_state_monitor.
`timescale 1ns / 1ps

module tb_battery_power_state_monitor;
  import bpsm_pkg::*;

  localparam int unsigned ClkHalf       = 6;
  localparam int unsigned ResetCycles   = 8;
  // two-register pipeline, so this settle time covers anything still in flight
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned EndCycles     = 16;
  localparam int unsigned HoldOffCycles = 64;
  // longest legal quiet stretch is a long stall plus the hold-off, well under this
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 216;
  localparam int unsigned HoldOffPhase  = 3;
  localparam int unsigned MaxReported   = 50;

  // indexes past the register map; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgUnmappedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnmappedHi = 3'd7;

  localparam logic [MvW-1:0] MvMax = '1;
  localparam logic [MsW-1:0] MsMax = '1;

  // charge thresholds in mV, one per ten percent
  localparam int unsigned ChargeStepMv [10] = '{
    3000, 3780, 3830, 3870, 3890, 3920, 3960, 4000, 4040, 4100
  };

  typedef enum int {
    SET_FLOOR,    // every register at zero
    SET_CEILING,  // every register at its largest value
    SET_FIELD     // random thresholds and timeouts close to real use
  } setting_e;

  localparam setting_e PhasePlan [8] = '{
    SET_FLOOR, SET_FIELD, SET_FIELD, SET_FIELD,
    SET_CEILING, SET_FIELD, SET_FIELD, SET_FIELD
  };

  typedef struct {
    sample_t stim;
    bit      typed;   // expected status written in the table, not predicted
    result_t status;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [MvW-1:0]    voltage_mv_i  = '0;
  logic              is_charging_i = 1'b0;
  logic              power_good_i  = 1'b0;
  logic [MsW-1:0]    now_ms_i      = '0;
  logic [MsW-1:0]    inactive_ms_i = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [LevelW-1:0] level_pct_o;
  logic [1:0]        power_state_o;
  logic              state_changed_o;
  logic              may_fly_o;
  logic              shutdown_req_o;
  logic              report_pulse_o;
  logic [MvW-1:0]    min_mv_o;
  logic [MvW-1:0]    max_mv_o;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  battery_power_state_monitor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .voltage_mv_i    (voltage_mv_i),
    .is_charging_i   (is_charging_i),
    .power_good_i    (power_good_i),
    .now_ms_i        (now_ms_i),
    .inactive_ms_i   (inactive_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .level_pct_o     (level_pct_o),
    .power_state_o   (power_state_o),
    .state_changed_o (state_changed_o),
    .may_fly_o       (may_fly_o),
    .shutdown_req_o  (shutdown_req_o),
    .report_pulse_o  (report_pulse_o),
    .min_mv_o        (min_mv_o),
    .max_mv_o        (max_mv_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Monitor state mirror: registers as last written, tracking state after reset
  // ---------------------------------------------------------------------------
  cfg_t cfg_mirror = '{LowVoltageRst, CriticalVoltageRst, LowTimeoutRst,
                       CriticalTimeoutRst, IdleShutdownRst, ReportIntervalRst};
  logic [MvW-1:0] seen_min     = SeenRst;
  logic [MvW-1:0] seen_max     = SeenRst;
  logic [MsW-1:0] low_stamp    = '0;
  logic [MsW-1:0] crit_stamp   = '0;
  logic [MsW-1:0] report_stamp = '0;
  power_state_e   prior_status = PS_BATTERY;

  result_t     expected_status [$];
  int unsigned mismatch_count = 0;
  bit          hold_off_req   = 1'b0;
  int unsigned tx_calm_left   = 0;

  // Charge level: 0 below the first threshold, 90 above the last, otherwise
  // ten times the index of the first threshold at or above the voltage.
  function automatic logic [LevelW-1:0] charge_level(input logic [MvW-1:0] mv);
    int unsigned k;
    k = 0;
    if (mv > ChargeStepMv[9]) begin
      k = 9;
    end else if (mv >= ChargeStepMv[0]) begin
      while (k < 9 && mv > ChargeStepMv[k]) k++;
    end
    return LevelW'(k * 10);
  endfunction

  // Advances the mirrored state by one accepted sample and returns its status.
  function automatic result_t predict_status(input sample_t s);
    result_t        r;
    power_state_e   st;
    logic [MsW-1:0] since_report;
    logic [MsW-1:0] since_low;
    logic [MsW-1:0] since_crit;
    if (s.voltage_mv > seen_max) seen_max = s.voltage_mv;
    if (s.voltage_mv < seen_min) seen_min = s.voltage_mv;

    // all time differences wrap modulo 2^32
    since_report   = s.now_ms - report_stamp;
    r.report_pulse = 1'b0;
    if (since_report >= cfg_mirror.report_interval_ms) begin
      report_stamp   = s.now_ms;
      r.report_pulse = 1'b1;
    end

    // timers restart while the voltage stays above their thresholds
    if (s.voltage_mv > cfg_mirror.low_voltage_mv) low_stamp = s.now_ms;
    if (s.voltage_mv > cfg_mirror.critical_voltage_mv) crit_stamp = s.now_ms;
    since_low  = s.now_ms - low_stamp;
    since_crit = s.now_ms - crit_stamp;

    if (s.power_good && !s.is_charging) begin
      st = PS_CHARGED;
    end else if (s.power_good) begin
      st = PS_CHARGING;
    end else if (!s.is_charging && since_low > cfg_mirror.low_timeout_ms) begin
      st = PS_LOWPOWER;
    end else begin
      st = PS_BATTERY;
    end

    r.level_pct     = charge_level(s.voltage_mv);
    r.power_state   = st;
    r.state_changed = (st != prior_status);
    prior_status    = st;
    r.may_fly       = (st == PS_BATTERY || st == PS_LOWPOWER);
    // critical timeout only counts in low power, inactivity only on battery
    r.shutdown_req  = (st == PS_LOWPOWER && since_crit > cfg_mirror.critical_timeout_ms) ||
                      (st == PS_BATTERY && s.inactive_ms > cfg_mirror.idle_shutdown_ms);
    r.min_mv        = seen_min;
    r.max_mv        = seen_max;
    return r;
  endfunction

  function automatic sample_t pack_sample(input int unsigned mv, input bit chg, input bit pg,
                                          input logic [MsW-1:0] now, input logic [MsW-1:0] idle);
    sample_t s;
    s.voltage_mv  = MvW'(mv);
    s.is_charging = chg;
    s.power_good  = pg;
    s.now_ms      = now;
    s.inactive_ms = idle;
    return s;
  endfunction

  function automatic result_t pack_status(input int unsigned lvl, input power_state_e st,
                                          input bit chg, input bit fly, input bit sd,
                                          input bit pulse, input int unsigned lo,
                                          input int unsigned hi);
    result_t r;
    r.level_pct     = LevelW'(lvl);
    r.power_state   = st;
    r.state_changed = chg;
    r.may_fly       = fly;
    r.shutdown_req  = sd;
    r.report_pulse  = pulse;
    r.min_mv        = MvW'(lo);
    r.max_mv        = MvW'(hi);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request drivers
  // ---------------------------------------------------------------------------
  // Holds the sample request until accepted; valid stays high on return so a
  // back-to-back request never lowers and raises it in the same step.
  task automatic offer_sample(input sample_t s, output result_t predicted);
    in_valid_i    <= 1'b1;
    voltage_mv_i  <= s.voltage_mv;
    is_charging_i <= s.is_charging;
    power_good_i  <= s.power_good;
    now_ms_i      <= s.now_ms;
    inactive_ms_i <= s.inactive_ms;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_status(s);
  endtask

  // Gap after a sample request: mostly none or short, a few long, with calm runs.
  task automatic sample_gap();
    int unsigned n;
    n = 0;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else begin
      case ($urandom_range(0, 19))
        0:             n = $urandom_range(10, 40);
        1, 2, 3, 4, 5: n = $urandom_range(1, 3);
        6:             tx_calm_left = $urandom_range(20, 60);
        default:       n = 0;
      endcase
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Register write request; valid is left high for the next write of a batch.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_LOW_VOLTAGE:      cfg_mirror.low_voltage_mv      = data[MvW-1:0];
      CFG_CRITICAL_VOLTAGE: cfg_mirror.critical_voltage_mv = data[MvW-1:0];
      CFG_LOW_TIMEOUT:      cfg_mirror.low_timeout_ms      = data;
      CFG_CRITICAL_TIMEOUT: cfg_mirror.critical_timeout_ms = data;
      CFG_IDLE_SHUTDOWN:    cfg_mirror.idle_shutdown_ms    = data;
      CFG_REPORT_INTERVAL:  cfg_mirror.report_interval_ms  = data;
      default: ;
    endcase
  endtask

  // Sender pauses until every expected status is back, then lets the pipe settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_backpressure
    int unsigned stall_left;
    int unsigned calm_left;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        // counted here so the sender keeps offering and the pipe fills
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left > 0) begin
        calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            stall_left = $urandom_range(10, 40);
            out_stall_i <= 1'b1;
          end
          1, 2, 3, 4, 5: begin
            stall_left = $urandom_range(0, 2);
            out_stall_i <= 1'b1;
          end
          6: begin
            calm_left = $urandom_range(30, 100);
            out_stall_i <= 1'b0;
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Checks each accepted status against the oldest expectation, field by field.
  always @(posedge clk_i) begin : status_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        report_mismatch("status with no pending sample, level_pct", level_pct_o, 0);
      end else begin
        want = expected_status.pop_front();
        if (level_pct_o !== want.level_pct)
          report_mismatch("level_pct", level_pct_o, want.level_pct);
        if (power_state_o !== want.power_state)
          report_mismatch("power_state", power_state_o, want.power_state);
        if (state_changed_o !== want.state_changed)
          report_mismatch("state_changed", state_changed_o, want.state_changed);
        if (may_fly_o !== want.may_fly)
          report_mismatch("may_fly", may_fly_o, want.may_fly);
        if (shutdown_req_o !== want.shutdown_req)
          report_mismatch("shutdown_req", shutdown_req_o, want.shutdown_req);
        if (report_pulse_o !== want.report_pulse)
          report_mismatch("report_pulse", report_pulse_o, want.report_pulse);
        if (min_mv_o !== want.min_mv)
          report_mismatch("min_mv", min_mv_o, want.min_mv);
        if (max_mv_o !== want.max_mv)
          report_mismatch("max_mv", max_mv_o, want.max_mv);
      end
    end
  end

  // Ends the run when no request of any channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table under reset settings, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t       directed_rows [$];
    sample_t        s;
    result_t        predicted;
    int unsigned    walk_mv;
    logic [MsW-1:0] walk_now;
    logic [MsW-1:0] walk_idle;
    logic [MsW-1:0] step;
    bit             walk_chg;
    bit             walk_pg;
    logic [MvW-1:0] lv;
    logic [MvW-1:0] cv;
    logic [MsW-1:0] lt;
    logic [MsW-1:0] ct;
    logic [MsW-1:0] it;
    logic [MsW-1:0] ri;

    walk_mv   = 3700;
    walk_now  = '0;
    walk_idle = '0;
    walk_chg  = 1'b0;
    walk_pg   = 1'b0;

    // Typed rows follow the reset settings: low 3200, critical 3000,
    // both timeouts 5000, idle 300000, report every 1000 ms.
    // first sample after reset: nothing moves, level 10
    directed_rows.push_back('{pack_sample(3700, 0, 0, 32'd0, 32'd0), 1'b1,
                              pack_status(10, PS_BATTERY, 0, 1, 0, 0, 3700, 3700)});
    // zero volts, report interval just reached
    directed_rows.push_back('{pack_sample(0, 0, 0, 32'd1000, 32'd0), 1'b1,
                              pack_status(0, PS_BATTERY, 0, 1, 0, 1, 0, 3700)});
    // top voltage while charging; inactivity is ignored off battery
    directed_rows.push_back('{pack_sample(MvMax, 1, 1, 32'd1500, MsMax), 1'b1,
                              pack_status(90, PS_CHARGING, 1, 0, 0, 0, 0, 16383)});
    // last threshold exactly, charged
    directed_rows.push_back('{pack_sample(4100, 0, 1, 32'd2000, MsMax), 1'b1,
                              pack_status(90, PS_CHARGED, 1, 0, 0, 1, 0, 16383)});
    // charging flag without external power is battery; inactivity one past limit
    directed_rows.push_back('{pack_sample(4101, 1, 0, 32'd2100, 32'd300001), 1'b1,
                              pack_status(90, PS_BATTERY, 1, 1, 1, 0, 0, 16383)});
    // first threshold exactly, inactivity at the limit is not enough
    directed_rows.push_back('{pack_sample(3000, 0, 0, 32'd2200, 32'd300000), 1'b1,
                              pack_status(0, PS_BATTERY, 0, 1, 0, 0, 0, 16383)});
    // low timer at exactly its timeout stays on battery
    directed_rows.push_back('{pack_sample(3001, 0, 0, 32'd7100, 32'd0), 1'b1,
                              pack_status(10, PS_BATTERY, 0, 1, 0, 1, 0, 16383)});
    // one past the low timeout: low power
    directed_rows.push_back('{pack_sample(2999, 0, 0, 32'd7101, 32'd0), 1'b1,
                              pack_status(0, PS_LOWPOWER, 1, 1, 0, 0, 0, 16383)});
    // critical timer at exactly its timeout: no shutdown yet
    directed_rows.push_back('{pack_sample(2999, 0, 0, 32'd12100, 32'd0), 1'b1,
                              pack_status(0, PS_LOWPOWER, 0, 1, 0, 1, 0, 16383)});
    // one past the critical timeout: shutdown request
    directed_rows.push_back('{pack_sample(2999, 0, 0, 32'd12101, 32'd0), 1'b1,
                              pack_status(0, PS_LOWPOWER, 0, 1, 1, 0, 0, 16383)});
    // charger flag leaves low power
    directed_rows.push_back('{pack_sample(2999, 1, 0, 32'd12102, 32'd0), 1'b1,
                              pack_status(0, PS_BATTERY, 1, 1, 0, 0, 0, 16383)});
    // tick at its top value
    directed_rows.push_back('{pack_sample(3780, 0, 0, MsMax, 32'd0), 1'b1,
                              pack_status(10, PS_BATTERY, 0, 1, 0, 1, 0, 16383)});
    // tick wraps to zero: elapsed report time is one
    directed_rows.push_back('{pack_sample(3781, 0, 0, 32'd0, 32'd0), 1'b1,
                              pack_status(20, PS_BATTERY, 0, 1, 0, 0, 0, 16383)});
    // the remaining level boundaries and flag mixes go through the predictor
    directed_rows.push_back('{pack_sample(3830, 0, 0, 32'd100, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3831, 0, 0, 32'd200, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3870, 0, 0, 32'd300, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3871, 0, 1, 32'd400, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3890, 1, 1, 32'd500, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3920, 0, 0, 32'd600, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(3960, 0, 0, 32'd700, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(4000, 0, 0, 32'd800, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(4040, 0, 0, 32'd900, 32'd0), 1'b0, '0});
    directed_rows.push_back('{pack_sample(4041, 0, 0, 32'd1000, 32'd300001), 1'b0, '0});

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      offer_sample(directed_rows[i].stim, predicted);
      expected_status.push_back(directed_rows[i].typed ? directed_rows[i].status : predicted);
      sample_gap();
    end

    foreach (PhasePlan[p]) begin
      // registers only change with the pipe empty
      drain_results();
      case (PhasePlan[p])
        SET_FLOOR: begin
          lv = '0; cv = '0; lt = '0; ct = '0; it = '0; ri = '0;
        end
        SET_CEILING: begin
          lv = MvMax; cv = MvMax; lt = MsMax; ct = MsMax; it = MsMax; ri = MsMax;
        end
        default: begin
          lv = MvW'($urandom_range(2800, 3600));
          cv = MvW'($urandom_range(2700, lv));
          lt = $urandom_range(0, 3000);
          ct = $urandom_range(0, 3000);
          it = $urandom_range(0, 8000);
          ri = $urandom_range(1, 1500);
        end
      endcase
      // voltage registers get junk above bit 13, which must be dropped
      write_reg(CFG_LOW_VOLTAGE, {18'($urandom), lv});
      write_reg(CFG_CRITICAL_VOLTAGE, {18'($urandom), cv});
      write_reg(CFG_LOW_TIMEOUT, lt);
      write_reg(CFG_CRITICAL_TIMEOUT, ct);
      write_reg(CFG_IDLE_SHUTDOWN, it);
      write_reg(CFG_REPORT_INTERVAL, ri);
      write_reg(CfgUnmappedLo, $urandom);
      write_reg(CfgUnmappedHi, $urandom);
      cfg_valid_i <= 1'b0;

      if (p == HoldOffPhase) hold_off_req = 1'b1;

      repeat (PhaseItems) begin
        if ($urandom_range(0, 7) == 0) begin
          // noise: any value in any field
          s.voltage_mv  = MvW'($urandom);
          s.is_charging = 1'($urandom);
          s.power_good  = 1'($urandom);
          s.now_ms      = $urandom;
          s.inactive_ms = $urandom;
        end else begin
          // periodic samples: time moves forward, voltage drifts, flags mostly sticky
          case ($urandom_range(0, 19))
            0:       step = '0;
            1:       step = $urandom;  // big jump, may wrap backward
            default: step = $urandom_range(1, 400);
          endcase
          walk_now = walk_now + step;
          if ($urandom_range(0, 9) == 0) walk_idle = '0;
          else walk_idle = walk_idle + step;
          if ($urandom_range(0, 19) == 0) begin
            walk_mv = $urandom_range(2700, 4300);
          end else begin
            walk_mv = walk_mv + $urandom_range(0, 120) - 60;
            if (walk_mv < 2700) walk_mv = 2700;
            if (walk_mv > 4300) walk_mv = 4300;
          end
          if ($urandom_range(0, 14) == 0) begin
            // half the time back on battery, which the timers need
            if ($urandom_range(0, 1) == 0) {walk_chg, walk_pg} = 2'b00;
            else {walk_chg, walk_pg} = 2'($urandom);
          end
          s = pack_sample(walk_mv, walk_chg, walk_pg, walk_now, walk_idle);
        end
        offer_sample(s, predicted);
        expected_status.push_back(predicted);
        sample_gap();
      end
    end

    drain_results();
    repeat (EndCycles) @(posedge clk_i);
    if (expected_status.size() != 0)
      report_mismatch("statuses still pending", expected_status.size(), 0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bpsm_pkg.sv
rtl/core/bpsm_cfg.sv
rtl/core/bpsm_eval.sv
rtl/core/battery_power_state_monitor.sv
tb/sv/tb_battery_power_state_monitor.sv
